[rtl/core/fbcs_pkg.sv]
`default_nettype none

package fbcs_pkg;

    // number of joints with an alarm byte
    localparam int unsigned JOINTS = 6;
    localparam logic [2:0] JOINT_LIM = 3'(JOINTS);
    localparam logic [2:0] NONE_IDX = 3'd7;

    // configuration register indexes
    localparam logic [2:0] CFG_BLINK_PERIOD   = 3'd0;
    localparam logic [2:0] CFG_GREEN_PERIOD   = 3'd1;
    localparam logic [2:0] CFG_DEBOUNCE_TICKS = 3'd2;
    localparam logic [2:0] CFG_PAUSE_SLOTS    = 3'd3;
    localparam logic [2:0] CFG_GREEN_FLASHES  = 3'd4;

    // request kinds
    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // thermal status codes
    localparam logic [1:0] THERM_WARN     = 2'd1;
    localparam logic [1:0] THERM_SHUTDOWN = 2'd2;

    // red sequencer phases
    localparam logic [1:0] RED_ON    = 2'd0;
    localparam logic [1:0] RED_OFF   = 2'd1;
    localparam logic [1:0] RED_PAUSE = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [2:0] joint;
        logic       ocd;
        logic [1:0] thermal;
        logic       uvlo;
        logic       adc_uvlo;
        logic       stall_req;
        logic       sw_event;
        logic       cmd_fault;
        logic       button;
    } in_beat_t;

    typedef struct packed {
        logic        red_led;
        logic        green_led;
        logic [47:0] fault_word;
        logic [47:0] first_fault;
        logic [2:0]  shown_joint;
        logic        any_fault;
    } out_beat_t;

    // blink code of an alarm byte, never zero
    function automatic logic [2:0] blink_code(input logic [7:0] a);
        logic [2:0] c;
        begin
            if (a[0])
                c = 3'd1;
            else if (a[2:1] != 2'b00)
                c = 3'd2;
            else if (a[4:3] != 2'b00)
                c = 3'd3;
            else if (a[5])
                c = 3'd4;
            else if (a[6])
                c = 3'd5;
            else if (a[7])
                c = 3'd6;
            else
                c = 3'd1;
            return c;
        end
    endfunction

    // first faulted joint at or after start, wrapping, NONE_IDX if none
    function automatic logic [2:0] next_faulted(input logic [7:0] nz, input logic [2:0] start);
        logic [3:0] s;
        logic [3:0] idx;
        logic [2:0] res;
        logic       found;
        begin
            s = {1'b0, start};
            for (int k = 0; k < 8; k++)
            begin
                if (s >= 4'(JOINTS))
                    s = s - 4'(JOINTS);
            end
            res = NONE_IDX;
            found = 1'b0;
            for (int i = 0; i < JOINTS; i++)
            begin
                idx = s + 4'(i);
                if (idx >= 4'(JOINTS))
                    idx = idx - 4'(JOINTS);
                if (!found && nz[idx[2:0]])
                begin
                    res = idx[2:0];
                    found = 1'b1;
                end
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/fault_blink_code_sequencer_core.sv]
`default_nettype none

// Fault blink-code sequencer. Each input beat is either a driver status report
// for one joint (req_type 0), which rewrites that joint's alarm byte, or a loop
// tick (req_type 1), which samples the button, advances the saturating tick
// counters and steps the green flash run or the red round-robin that blinks
// each faulted joint's priority code (overcurrent 1, thermal 2, undervoltage 3,
// stall 4, switch event 5, command error 6). Every input beat yields exactly one
// output beat carrying the LED drives, the packed 48-bit fault word, the first
// nonzero fault word latched on a tick, the joint being shown (7 = none) and an
// any-fault flag. The whole update is one pass of logic from the accepted beat
// and the state registers into the output register, so a new beat is taken
// every cycle while the output register is empty or being drained.
// Configuration writes are always accepted (cfg_ready is tied high) and
// should only be made while the block is idle.
module fault_blink_code_sequencer_core
    import fbcs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    // input channel
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_beat_t  in_data,
    // output channel
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_beat_t      out_data,
    // configuration write channel
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    // configuration registers
    logic [7:0] blink_period_reg;
    logic [7:0] green_period_reg;
    logic [7:0] debounce_ticks_reg;
    logic [2:0] pause_slots_reg;
    logic [2:0] green_flashes_reg;

    // sequencer state
    logic [7:0]  alarm_reg [JOINTS];
    logic [7:0]  alarm_next [JOINTS];
    logic [2:0]  shown_idx_reg,   shown_idx_next;
    logic [2:0]  blinks_done_reg, blinks_done_next;
    logic [2:0]  blink_total_reg, blink_total_next;
    logic [1:0]  red_phase_reg,   red_phase_next;
    logic [2:0]  pause_left_reg,  pause_left_next;
    logic [7:0]  red_timer_reg,   red_timer_next;
    logic [2:0]  green_left_reg,  green_left_next;
    logic        green_phase_reg, green_phase_next;
    logic [7:0]  green_timer_reg, green_timer_next;
    logic        button_prev_reg, button_prev_next;
    logic [7:0]  press_timer_reg, press_timer_next;
    logic [47:0] latched_reg,     latched_next;
    logic        red_state_reg,   red_state_next;
    logic        green_state_reg, green_state_next;

    // output register
    logic        out_valid_reg;
    out_beat_t   out_reg, out_next;

    logic        in_fire;

    // alarm bytes padded to eight entries, zero past the last joint
    logic [7:0]  alarm_ext [8];
    logic [7:0]  nz_now;
    logic        any_now;
    logic [7:0]  nz_after;
    logic [47:0] fault_word_after;
    logic [7:0]  report_byte;
    logic        press;
    logic [2:0]  nx;

    assign in_fire   = in_valid && in_ready;
    // output register frees up as it drains, so beats keep flowing
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            alarm_ext[i] = 8'h00;
        for (int i = 0; i < JOINTS; i++)
            alarm_ext[i] = alarm_reg[i];
        for (int i = 0; i < 8; i++)
            nz_now[i] = (alarm_ext[i] != 8'h00);
        any_now = (nz_now != 8'h00);
    end

    // alarm byte built from a status report
    always_comb
    begin
        report_byte = {in_data.cmd_fault, in_data.sw_event, in_data.stall_req,
                       in_data.adc_uvlo, in_data.uvlo,
                       in_data.thermal == THERM_WARN,
                       in_data.thermal == THERM_SHUTDOWN,
                       in_data.ocd};
    end

    // one pass of the sequencer for the beat at the input
    always_comb
    begin
        for (int i = 0; i < JOINTS; i++)
            alarm_next[i] = alarm_reg[i];
        shown_idx_next   = shown_idx_reg;
        blinks_done_next = blinks_done_reg;
        blink_total_next = blink_total_reg;
        red_phase_next   = red_phase_reg;
        pause_left_next  = pause_left_reg;
        red_timer_next   = red_timer_reg;
        green_left_next  = green_left_reg;
        green_phase_next = green_phase_reg;
        green_timer_next = green_timer_reg;
        button_prev_next = button_prev_reg;
        press_timer_next = press_timer_reg;
        latched_next     = latched_reg;
        red_state_next   = red_state_reg;
        green_state_next = green_state_reg;
        press            = 1'b0;
        nx               = NONE_IDX;

        if (in_data.req_type == REQ_REPORT)
        begin
            // reports for joints past the last one are dropped
            for (int i = 0; i < JOINTS; i++)
            begin
                if (in_data.joint == 3'(i))
                    alarm_next[i] = report_byte;
            end
        end
        else
        begin
            // saturating tick counters
            red_timer_next   = (red_timer_reg == 8'hFF) ? 8'hFF : red_timer_reg + 8'd1;
            green_timer_next = (green_timer_reg == 8'hFF) ? 8'hFF : green_timer_reg + 8'd1;
            press_timer_next = (press_timer_reg == 8'hFF) ? 8'hFF : press_timer_reg + 8'd1;

            // debounced falling edge of the button
            press = button_prev_reg && !in_data.button
                    && (press_timer_next > debounce_ticks_reg);
            if (press)
            begin
                press_timer_next = 8'h00;
                if (any_now)
                begin
                    shown_idx_next   = next_faulted(nz_now, 3'd0);
                    blinks_done_next = 3'd0;
                    blink_total_next = blink_code(alarm_ext[shown_idx_next]);
                    red_phase_next   = RED_ON;
                    pause_left_next  = 3'd0;
                    red_state_next   = 1'b1;
                    red_timer_next   = 8'h00;
                end
                else
                begin
                    green_left_next  = green_flashes_reg;
                    green_phase_next = 1'b0;
                    green_timer_next = 8'h00;
                    green_state_next = 1'b1;
                end
            end
            button_prev_next = in_data.button;

            if (any_now && latched_reg == 48'h0)
                latched_next = fault_word_after;

            if (green_left_next != 3'd0)
            begin
                // green flash run takes the tick
                if (green_timer_next >= green_period_reg)
                begin
                    green_timer_next = 8'h00;
                    if (!green_phase_next)
                    begin
                        green_state_next = 1'b0;
                        green_phase_next = 1'b1;
                    end
                    else
                    begin
                        green_left_next  = green_left_next - 3'd1;
                        green_state_next = (green_left_next != 3'd0);
                        green_phase_next = 1'b0;
                    end
                end
            end
            else if (red_timer_next >= blink_period_reg)
            begin
                red_timer_next = 8'h00;
                if (shown_idx_next >= JOINT_LIM || alarm_ext[shown_idx_next] == 8'h00)
                begin
                    // current joint cleared or nothing shown: move on
                    shown_idx_next = next_faulted(nz_now, shown_idx_next + 3'd1);
                    if (shown_idx_next >= JOINT_LIM)
                        red_state_next = 1'b0;
                    else
                    begin
                        blinks_done_next = 3'd0;
                        blink_total_next = blink_code(alarm_ext[shown_idx_next]);
                        red_phase_next   = RED_ON;
                        pause_left_next  = 3'd0;
                        red_state_next   = 1'b1;
                    end
                end
                else
                begin
                    case (red_phase_next)
                        RED_ON:
                        begin
                            red_state_next = 1'b0;
                            red_phase_next = RED_OFF;
                        end
                        RED_OFF:
                        begin
                            blinks_done_next = blinks_done_next + 3'd1;
                            if (blinks_done_next >= blink_total_next)
                            begin
                                red_phase_next  = RED_PAUSE;
                                pause_left_next = pause_slots_reg;
                            end
                            else
                            begin
                                red_phase_next = RED_ON;
                                red_state_next = 1'b1;
                            end
                        end
                        RED_PAUSE:
                        begin
                            // zero pause wraps to eight dark steps
                            pause_left_next = pause_left_next - 3'd1;
                            if (pause_left_next == 3'd0)
                            begin
                                nx = next_faulted(nz_now, shown_idx_next + 3'd1);
                                if (nx >= JOINT_LIM || nx == shown_idx_next)
                                    nx = next_faulted(nz_now, 3'd0);
                                shown_idx_next   = (nx >= JOINT_LIM) ? NONE_IDX : nx;
                                blinks_done_next = 3'd0;
                                red_phase_next   = RED_ON;
                                pause_left_next  = 3'd0;
                                if (shown_idx_next < JOINT_LIM)
                                begin
                                    blink_total_next = blink_code(alarm_ext[shown_idx_next]);
                                    red_state_next   = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            red_phase_next = red_phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    // fault word and flag after this beat's report
    always_comb
    begin
        fault_word_after = 48'h0;
        nz_after = 8'h00;
        for (int i = 0; i < JOINTS; i++)
        begin
            nz_after[i] = (alarm_next[i] != 8'h00);
            if (i < 6)
                fault_word_after[8*i +: 8] = alarm_next[i];
        end
    end

    always_comb
    begin
        out_next.red_led     = red_state_next;
        out_next.green_led   = green_state_next;
        out_next.fault_word  = fault_word_after;
        out_next.first_fault = latched_next;
        out_next.shown_joint = shown_idx_next;
        out_next.any_fault   = (nz_after != 8'h00);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_period_reg   <= 8'd12;
            green_period_reg   <= 8'd10;
            debounce_ticks_reg <= 8'd5;
            pause_slots_reg    <= 3'd5;
            green_flashes_reg  <= 3'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BLINK_PERIOD:   blink_period_reg   <= cfg_data;
                CFG_GREEN_PERIOD:   green_period_reg   <= cfg_data;
                CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data;
                CFG_PAUSE_SLOTS:    pause_slots_reg    <= cfg_data[2:0];
                CFG_GREEN_FLASHES:  green_flashes_reg  <= cfg_data[2:0];
                default:            blink_period_reg   <= blink_period_reg;
            endcase
        end
    end

    // sequencer state, updated once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < JOINTS; i++)
                alarm_reg[i] <= 8'h00;
            shown_idx_reg   <= NONE_IDX;
            blinks_done_reg <= 3'd0;
            blink_total_reg <= 3'd0;
            red_phase_reg   <= RED_ON;
            pause_left_reg  <= 3'd0;
            red_timer_reg   <= 8'hFF;
            green_left_reg  <= 3'd0;
            green_phase_reg <= 1'b0;
            green_timer_reg <= 8'h00;
            button_prev_reg <= 1'b1;
            press_timer_reg <= 8'hFF;
            latched_reg     <= 48'h0;
            red_state_reg   <= 1'b0;
            green_state_reg <= 1'b1;
        end
        else if (in_fire)
        begin
            for (int i = 0; i < JOINTS; i++)
                alarm_reg[i] <= alarm_next[i];
            shown_idx_reg   <= shown_idx_next;
            blinks_done_reg <= blinks_done_next;
            blink_total_reg <= blink_total_next;
            red_phase_reg   <= red_phase_next;
            pause_left_reg  <= pause_left_next;
            red_timer_reg   <= red_timer_next;
            green_left_reg  <= green_left_next;
            green_phase_reg <= green_phase_next;
            green_timer_reg <= green_timer_next;
            button_prev_reg <= button_prev_next;
            press_timer_reg <= press_timer_next;
            latched_reg     <= latched_next;
            red_state_reg   <= red_state_next;
            green_state_reg <= green_state_next;
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_reg <= out_next;
    end

`ifndef SYNTHESIS
    // shown joint is a real joint or none
    assert property (@(posedge clk) disable iff (!rst_n)
        (shown_idx_reg < JOINT_LIM) || (shown_idx_reg == NONE_IDX))
        else $error("shown joint out of range");

    // first fault word never changes once latched
    assert property (@(posedge clk) disable iff (!rst_n)
        (latched_reg != 48'h0) |=> $stable(latched_reg))
        else $error("latched fault word changed");

    // red is lit only in the on phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (red_phase_reg != RED_ON) |-> !red_state_reg)
        else $error("red lit outside on phase");

    // every accepted beat produces an output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted beat lost");
`endif

endmodule

`default_nettype wire

[bench/tb_fault_blink_code_sequencer_core.sv]
`default_nettype none

module tb_fault_blink_code_sequencer_core;
    import fbcs_pkg::*;

    // watchdog on the whole run, far above the slowest legal run
    localparam int RUN_LIMIT = 200000;

    // clock, reset and block ports
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    // indicator model: register copy, reset values of the block
    logic [7:0] c_blink_period = 8'd12;
    logic [7:0] c_green_period = 8'd10;
    logic [7:0] c_debounce = 8'd5;
    logic [2:0] c_pause = 3'd5;
    logic [2:0] c_flashes = 3'd3;

    // indicator model: sequencer state
    logic [7:0]  m_alarm [0:7] = '{default: 8'd0};
    logic [2:0]  m_shown = NONE_IDX;
    logic [2:0]  m_done = 3'd0;
    logic [2:0]  m_total = 3'd0;
    logic [1:0]  m_red_phase = RED_ON;
    logic [2:0]  m_pause_left = 3'd0;
    logic [7:0]  m_red_timer = 8'hFF;
    logic [2:0]  m_green_left = 3'd0;
    logic        m_green_phase = 1'b0;
    logic [7:0]  m_green_timer = 8'd0;
    logic        m_button_prev = 1'b1;
    logic [7:0]  m_press_timer = 8'hFF;
    logic [47:0] m_latched = 48'd0;
    logic        m_red = 1'b0;
    logic        m_green = 1'b1;

    // led status beats still owed by the block, oldest first
    out_beat_t pending_status [$];

    int  errors = 0;
    int  cycle_count = 0;
    int  hold_len = 0;      // receiver hold-off cycles still to run
    bit  calm = 1'b0;       // no idling on either side while set
    bit  btn_level = 1'b1;  // button level carried across random ticks

    fault_blink_code_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 unit period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // ---------------------------------------------------------------
    // indicator model
    // ---------------------------------------------------------------

    function automatic logic [7:0] sat_up(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [47:0] packed_faults();
        logic [47:0] w;
        w = '0;
        for (int i = 0; i < JOINTS; i++)
            w[8*i +: 8] = m_alarm[i];
        return w;
    endfunction

    function automatic logic fault_present();
        for (int i = 0; i < JOINTS; i++)
            if (m_alarm[i] != 8'd0)
                return 1'b1;
        return 1'b0;
    endfunction

    // rotating search from start, wrapping over the joints
    function automatic logic [2:0] find_faulted(input int start);
        int idx;
        for (int i = 0; i < JOINTS; i++)
        begin
            idx = ((start & 7) + i) % JOINTS;
            if (m_alarm[idx] != 8'd0)
                return idx[2:0];
        end
        return NONE_IDX;
    endfunction

    // load the blink count of the shown joint, highest priority flag wins
    task automatic start_joint();
        logic [7:0] a;
        a = m_alarm[m_shown];
        m_done = 3'd0;
        if (a[0])
            m_total = 3'd1;
        else if (a[2:1] != 2'b00)
            m_total = 3'd2;
        else if (a[4:3] != 2'b00)
            m_total = 3'd3;
        else if (a[5])
            m_total = 3'd4;
        else if (a[6])
            m_total = 3'd5;
        else if (a[7])
            m_total = 3'd6;
        else
            m_total = 3'd1;
        m_red_phase = RED_ON;
        m_pause_left = 3'd0;
        m_red = 1'b1;
    endtask

    // one accepted input beat -> the status beat it produces
    task automatic step_indicator_model(input in_beat_t b, output out_beat_t r);
        logic [2:0] nx;
        if (b.req_type == REQ_REPORT)
        begin
            // reports past the last joint leave everything alone
            if (b.joint < JOINT_LIM)
                m_alarm[b.joint] = {b.cmd_fault, b.sw_event, b.stall_req, b.adc_uvlo,
                                    b.uvlo, b.thermal == THERM_WARN,
                                    b.thermal == THERM_SHUTDOWN, b.ocd};
        end
        else
        begin
            m_red_timer = sat_up(m_red_timer);
            m_green_timer = sat_up(m_green_timer);
            m_press_timer = sat_up(m_press_timer);

            // falling button edge outside the debounce window
            if (m_button_prev && !b.button && m_press_timer > c_debounce)
            begin
                m_press_timer = 8'd0;
                if (fault_present())
                begin
                    m_shown = find_faulted(0);
                    if (m_shown < JOINT_LIM)
                    begin
                        start_joint();
                        m_red_timer = 8'd0;
                    end
                end
                else
                begin
                    m_green_left = c_flashes;
                    m_green_phase = 1'b0;
                    m_green_timer = 8'd0;
                    m_green = 1'b1;
                end
            end
            m_button_prev = b.button;

            if (fault_present() && m_latched == 48'd0)
                m_latched = packed_faults();

            if (m_green_left != 3'd0)
            begin
                // green run owns the tick, red sequencer frozen
                if (m_green_timer >= c_green_period)
                begin
                    m_green_timer = 8'd0;
                    if (!m_green_phase)
                    begin
                        m_green = 1'b0;
                        m_green_phase = 1'b1;
                    end
                    else
                    begin
                        m_green = 1'b1;
                        m_green_left = m_green_left - 3'd1;
                        if (m_green_left == 3'd0)
                            m_green = 1'b0;
                        m_green_phase = 1'b0;
                    end
                end
            end
            else if (m_red_timer >= c_blink_period)
            begin
                m_red_timer = 8'd0;
                if (m_shown >= JOINT_LIM || m_alarm[m_shown] == 8'd0)
                begin
                    // shown joint gone or none shown: move on to the next fault
                    m_shown = find_faulted(m_shown + 1);
                    if (m_shown >= JOINT_LIM)
                        m_red = 1'b0;
                    else
                        start_joint();
                end
                else
                begin
                    case (m_red_phase)
                        RED_ON:
                        begin
                            m_red = 1'b0;
                            m_red_phase = RED_OFF;
                        end
                        RED_OFF:
                        begin
                            m_done = m_done + 3'd1;
                            if (m_done >= m_total)
                            begin
                                m_red_phase = RED_PAUSE;
                                m_pause_left = c_pause;
                            end
                            else
                            begin
                                m_red_phase = RED_ON;
                                m_red = 1'b1;
                            end
                        end
                        RED_PAUSE:
                        begin
                            // zero pause wraps the 3-bit countdown
                            m_pause_left = m_pause_left - 3'd1;
                            if (m_pause_left == 3'd0)
                            begin
                                nx = find_faulted(m_shown + 1);
                                if (nx >= JOINT_LIM || nx == m_shown)
                                    nx = find_faulted(0);
                                m_shown = (nx >= JOINT_LIM) ? NONE_IDX : nx;
                                m_done = 3'd0;
                                m_red_phase = RED_ON;
                                m_pause_left = 3'd0;
                                if (m_shown < JOINT_LIM)
                                    start_joint();
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end

        r.red_led = m_red;
        r.green_led = m_green;
        r.fault_word = packed_faults();
        r.first_fault = m_latched;
        r.shown_joint = m_shown;
        r.any_fault = fault_present();
    endtask

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // one input beat; valid stays up after acceptance until the next negedge
    task automatic send_beat(input in_beat_t b);
        out_beat_t want;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        step_indicator_model(b, want);
        pending_status.push_back(want);
    endtask

    // stop offering and wait until every owed status beat came back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_BLINK_PERIOD:   c_blink_period = val;
            CFG_GREEN_PERIOD:   c_green_period = val;
            CFG_DEBOUNCE_TICKS: c_debounce = val;
            CFG_PAUSE_SLOTS:    c_pause = val[2:0];
            CFG_GREEN_FLASHES:  c_flashes = val[2:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // whole register set, only once the block has gone quiet
    task automatic apply_settings(input logic [7:0] blink, input logic [7:0] green,
                                  input logic [7:0] debounce, input logic [2:0] pause,
                                  input logic [2:0] flashes);
        drain_results();
        write_register(CFG_BLINK_PERIOD, blink);
        write_register(CFG_GREEN_PERIOD, green);
        write_register(CFG_DEBOUNCE_TICKS, debounce);
        write_register(CFG_PAUSE_SLOTS, {5'd0, pause});
        write_register(CFG_GREEN_FLASHES, {5'd0, flashes});
    endtask

    // flag order: ocd, uvlo, adc undervoltage, stall, switch event, command error
    function automatic in_beat_t report_beat(input logic [2:0] j, input logic [5:0] f,
                                             input logic [1:0] th);
        in_beat_t b;
        b.req_type = REQ_REPORT;
        b.joint = j;
        b.ocd = f[0];
        b.thermal = th;
        b.uvlo = f[1];
        b.adc_uvlo = f[2];
        b.stall_req = f[3];
        b.sw_event = f[4];
        b.cmd_fault = f[5];
        b.button = 1'b1;
        return b;
    endfunction

    function automatic in_beat_t tick_beat(input logic btn);
        in_beat_t b;
        b = '0;
        b.req_type = REQ_TICK;
        b.joint = 3'($urandom_range(7));
        b.button = btn;
        return b;
    endfunction

    // mostly ticks with slow button toggling; reports clear a joint clear_pct of the time
    function automatic in_beat_t random_beat(input int clear_pct);
        in_beat_t b;
        if ($urandom_range(99) < 25)
        begin
            b = report_beat(($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                                      : 3'($urandom_range(5)),
                            6'd0, 2'($urandom_range(3)));
            if ($urandom_range(99) < clear_pct)
                b.thermal = ($urandom_range(1) == 0) ? 2'd0 : 2'd3;
            else
            begin
                b.ocd = ($urandom_range(5) == 0);
                b.uvlo = ($urandom_range(5) == 0);
                b.adc_uvlo = ($urandom_range(5) == 0);
                b.stall_req = ($urandom_range(5) == 0);
                b.sw_event = ($urandom_range(5) == 0);
                b.cmd_fault = ($urandom_range(5) == 0);
            end
            b.button = 1'($urandom_range(1));
        end
        else
        begin
            if ($urandom_range(9) == 0)
                btn_level = ~btn_level;
            b = tick_beat(btn_level);
            b.ocd = 1'($urandom_range(1));
            b.thermal = 2'($urandom_range(3));
        end
        return b;
    endfunction

    task automatic send_random(input int count, input int clear_pct);
        for (int i = 0; i < count; i++)
            send_beat(random_beat(clear_pct));
    endtask

    // ---------------------------------------------------------------
    // receiver side: random stalls, or a counted hold-off when asked
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_len > 0)
        begin
            out_ready <= 1'b0;
            hold_len = hold_len - 1;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 35);
    end

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // each accepted status beat against the oldest prediction
    always @(posedge clk)
    begin : check_status
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: status beat with none pending, expected nothing, actual %h",
                         $time, out_data);
                errors++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("red_led", 48'(want.red_led), 48'(out_data.red_led));
                check_field("green_led", 48'(want.green_led), 48'(out_data.green_led));
                check_field("fault_word", want.fault_word, out_data.fault_word);
                check_field("first_fault", want.first_fault, out_data.first_fault);
                check_field("shown_joint", 48'(want.shown_joint),
                            48'(out_data.shown_joint));
                check_field("any_fault", 48'(want.any_fault), 48'(out_data.any_fault));
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset settings: every flag alone, ignored reports, green and red presses
    task automatic test_directed_cases();
        send_beat(tick_beat(1'b1));
        send_beat(tick_beat(1'b0));                       // press with no fault: green run
        send_beat(tick_beat(1'b1));
        send_beat(report_beat(3'd0, 6'b000000, 2'd0));
        send_beat(report_beat(3'd0, 6'b000001, 2'd0));    // overcurrent
        send_beat(report_beat(3'd1, 6'b000000, THERM_SHUTDOWN));
        send_beat(report_beat(3'd2, 6'b000000, THERM_WARN));
        send_beat(report_beat(3'd3, 6'b000010, 2'd0));    // undervoltage
        send_beat(report_beat(3'd3, 6'b000100, 2'd0));    // adc undervoltage
        send_beat(report_beat(3'd4, 6'b001000, 2'd0));    // stall
        send_beat(report_beat(3'd5, 6'b010000, 2'd0));    // switch event
        send_beat(report_beat(3'd7, 6'b111111, THERM_SHUTDOWN));  // joint out of range
        send_beat(report_beat(3'd6, 6'b111111, THERM_WARN));      // joint out of range
        send_beat(report_beat(3'd2, 6'b000000, 2'd3));    // thermal other sets nothing
        begin
            in_beat_t b;
            b = report_beat(3'd0, 6'b111111, THERM_SHUTDOWN);
            b.button = 1'b0;                              // button on a report is ignored
            send_beat(b);
        end
        send_beat(report_beat(3'd0, 6'b100000, 2'd0));    // command error alone
        send_beat(tick_beat(1'b1));
        send_beat(tick_beat(1'b0));                       // inside debounce window
        // fast settings so the round-robin moves within a few ticks
        apply_settings(8'd1, 8'd1, 8'd0, 3'd1, 3'd1);
        send_beat(tick_beat(1'b1));
        send_beat(tick_beat(1'b0));                       // press with faults: red starts
        for (int i = 0; i < 5; i++)
            send_beat(tick_beat(1'b1));
    endtask

    // zero periods, zero pause, zero flashes, then the top and low ends
    task automatic test_register_extremes();
        apply_settings(8'd0, 8'd0, 8'd0, 3'd0, 3'd0);
        calm = 1'b1;                                      // long stretch with no idling
        send_random(50, 40);
        calm = 1'b0;
        apply_settings(8'd255, 8'd255, 8'd255, 3'd7, 3'd7);
        send_random(30, 40);
        apply_settings(8'd1, 8'd1, 8'd0, 3'd1, 3'd1);
        send_random(40, 85);                              // mostly fault free: green runs
        apply_settings(8'd1, 8'd2, 8'd1, 3'd7, 3'd7);
        send_random(30, 85);
    endtask

    // receiver holds off while beats keep coming, so the input must stall
    task automatic test_output_backpressure();
        apply_settings(8'd2, 8'd2, 8'd1, 3'd2, 3'd3);
        hold_len = 80;
        send_random(40, 30);
    endtask

    // sender pauses mid-stream until every result is back
    task automatic test_idle_drain();
        send_random(15, 30);
        drain_results();
        send_random(15, 30);
    endtask

    // random settings per phase with mostly short periods
    task automatic test_random_round_robin();
        for (int p = 0; p < 5; p++)
        begin
            apply_settings(8'($urandom_range(3)), 8'($urandom_range(3)),
                           8'($urandom_range(4)), 3'($urandom_range(7)),
                           3'($urandom_range(7)));
            send_random(40, (p == 2) ? 85 : $urandom_range(60, 15));
        end
    endtask

    initial
    begin : watchdog
        wait (cycle_count >= RUN_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin : main_sequence
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_output_backpressure();
        test_idle_drain();
        test_random_round_robin();

        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
